@@ hw/rtl/sprite_row_pixel_blitter_core_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the sprite row blitter
// Clocked on clk, disabled during rst.
// ---------------------------------------------------------------------------
`ifndef SPRITE_ROW_PIXEL_BLITTER_CORE_MACROS_SVH
`define SPRITE_ROW_PIXEL_BLITTER_CORE_MACROS_SVH

// same-cycle implication
`define SRPB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRPB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/srpb_pkg.sv @@
// ---------------------------------------------------------------------------
// srpb_pkg
// Shared types, limits and the blend table of the sprite row blitter.
// ---------------------------------------------------------------------------
`default_nettype none

package srpb_pkg;

  localparam int SCREEN_LIMIT = 1024;
  localparam int DIM_W        = 11;
  localparam int COORD_W      = 16;
  localparam int LANES        = 8;
  localparam int LANE_W       = $clog2(LANES);

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1
  } reg_index_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [1:0]         color;
    logic               we;
  } pix_t;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic               layer;
  } row_t;

  localparam logic [1:0] BLEND_TAB [4][16] = '{
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1,
      2'd2, 2'd2, 2'd0, 2'd2, 2'd3, 2'd3, 2'd3, 2'd0},
    '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
      2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1,
      2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1},
    '{2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2,
      2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2}
  };

  // bit m set: mode m is opaque
  localparam logic [15:0] OPAQUE_MASK = 16'b0111_1011_1101_1111;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] d;
    d = v;
    if (d == '0) begin
      d = DIM_W'(1);
    end else if (d > DIM_W'(SCREEN_LIMIT)) begin
      d = DIM_W'(SCREEN_LIMIT);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sprite_row_pixel_blitter_core.sv @@
// A row beat loads the row bank; its pixels then pass the output register.
// Throughput: one pixel per cycle while out_stall does not hold the output, set
//   by the single output register draining the eight-entry row bank.
// A new row is taken while the previous one's last pixel leaves the bank.
// Reset: clears bank valid and output valid; screen size returns to 512 x 320.
// ---------------------------------------------------------------------------
// sprite_row_pixel_blitter_core
// Eight lanes blend one sprite row in parallel; a merge stage serializes it.
// ---------------------------------------------------------------------------
`default_nettype none

module sprite_row_pixel_blitter_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] origin_x,
  input  wire logic [15:0] origin_y,
  input  wire logic [2:0]  row_index,
  input  wire logic [7:0]  plane_low,
  input  wire logic [7:0]  plane_high,
  input  wire logic [3:0]  blend_mode,
  input  wire logic        flip_x,
  input  wire logic        flip_y,
  input  wire logic        two_bpp,
  input  wire logic        layer_select,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      pixel_x,
  output logic [15:0]      pixel_y,
  output logic [1:0]       pixel_color,
  output logic             pixel_layer,
  output logic             write_enable,
  output logic             last_pixel
);
  import srpb_pkg::*;

  logic [DIM_W-1:0]   screen_width;
  logic [DIM_W-1:0]   screen_height;
  logic [2:0]         yoff;
  logic [COORD_W-1:0] py;
  logic               row_inside;
  logic [7:0]         hi_plane;
  logic               load_ok;
  logic               load;
  pix_t               lanes [LANES];
  row_t               row;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= DIM_W'(512);
      screen_height <= DIM_W'(320);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= clamp_dim(cfg_data);
        REG_SCREEN_HEIGHT: screen_height <= clamp_dim(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    yoff       = flip_y ? ~row_index : row_index;
    py         = origin_y + {{(COORD_W-3){1'b0}}, yoff};
    row_inside = py < {{(COORD_W-DIM_W){1'b0}}, screen_height};
    hi_plane   = two_bpp ? plane_high : 8'd0;
    row.y      = py;
    row.layer  = layer_select;
    in_stall   = !load_ok;
    load       = in_valid && load_ok;
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    srpb_lane u_lane (
      .bit_pos      (LANE_W'(i)),
      .origin_x     (origin_x),
      .lo_bit       (plane_low[i]),
      .hi_bit       (hi_plane[i]),
      .blend_mode   (blend_mode),
      .flip_x       (flip_x),
      .row_inside   (row_inside),
      .screen_width (screen_width),
      .pix          (lanes[i])
    );
  end

  srpb_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .lanes        (lanes),
    .row          (row),
    .load_ok      (load_ok),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_color  (pixel_color),
    .pixel_layer  (pixel_layer),
    .write_enable (write_enable),
    .last_pixel   (last_pixel)
  );

endmodule

`default_nettype wire

@@ hw/rtl/srpb_lane.sv @@
// ---------------------------------------------------------------------------
// srpb_lane
// One pixel of a sprite row: column, blended color and write flag.
// ---------------------------------------------------------------------------
`default_nettype none

module srpb_lane (
  input  wire logic [2:0]                    bit_pos,
  input  wire logic [15:0]                   origin_x,
  input  wire logic                          lo_bit,
  input  wire logic                          hi_bit,
  input  wire logic [3:0]                    blend_mode,
  input  wire logic                          flip_x,
  input  wire logic                          row_inside,
  input  wire logic [srpb_pkg::DIM_W-1:0]    screen_width,
  output srpb_pkg::pix_t                     pix
);
  import srpb_pkg::*;

  logic [1:0]         code;
  logic [2:0]         xoff;
  logic [COORD_W-1:0] px;
  logic               drawn;

  always_comb begin
    code  = {hi_bit, lo_bit};
    // unflipped column is 7 - bit_pos
    xoff  = flip_x ? bit_pos : ~bit_pos;
    px    = origin_x + {{(COORD_W-3){1'b0}}, xoff};
    drawn = OPAQUE_MASK[blend_mode] || (code != 2'd0);
    pix.x     = px;
    pix.color = BLEND_TAB[code][blend_mode];
    pix.we    = drawn && row_inside &&
                (px < {{(COORD_W-DIM_W){1'b0}}, screen_width});
  end

endmodule

`default_nettype wire

@@ hw/rtl/srpb_merge.sv @@
// ---------------------------------------------------------------------------
// srpb_merge
// Row bank of lane results, drained one pixel per beat into the output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sprite_row_pixel_blitter_core_macros.svh"

module srpb_merge (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire srpb_pkg::pix_t         lanes [srpb_pkg::LANES],
  input  wire srpb_pkg::row_t         row,
  output logic                        load_ok,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [15:0]                 pixel_x,
  output logic [15:0]                 pixel_y,
  output logic [1:0]                  pixel_color,
  output logic                        pixel_layer,
  output logic                        write_enable,
  output logic                        last_pixel
);
  import srpb_pkg::*;

  pix_t              bank [LANES];
  row_t              bank_row;
  logic              bank_valid;
  logic [LANE_W-1:0] count;
  logic              advance;
  logic              last_move;

  always_comb begin
    advance   = bank_valid && (!out_valid || !out_stall);
    last_move = advance && (count == LANE_W'(LANES - 1));
    load_ok   = !bank_valid || last_move;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_valid <= 1'b0;
      count      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (load) begin
        bank_valid <= 1'b1;
        count      <= '0;
      end else begin
        if (last_move) begin
          bank_valid <= 1'b0;
        end
        if (advance) begin
          count <= count + LANE_W'(1);
        end
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bank     <= lanes;
      bank_row <= row;
    end
    if (advance) begin
      pixel_x      <= bank[count].x;
      pixel_color  <= bank[count].color;
      write_enable <= bank[count].we;
      pixel_y      <= bank_row.y;
      pixel_layer  <= bank_row.layer;
      last_pixel   <= (count == LANE_W'(LANES - 1));
    end
  end

  `SRPB_ASSERT_NOW(a_no_overwrite, load, !bank_valid || last_move, "bank overwritten")
  `SRPB_ASSERT_NEXT(a_last_flag, last_move, out_valid && last_pixel, "last pixel missing")
  `SRPB_ASSERT_NOW(a_idle_count, !bank_valid, count == '0, "count off while idle")

endmodule

`default_nettype wire
